/* sv/cbic_pkg.sv */
// shared types and constants of the centroid bias correction block
package cbic_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int AW          = $clog2(TABLE_DEPTH);
	localparam int BP_W        = 22;
	localparam int T2_W        = 23;
	localparam int PROD_W      = 57;
	localparam int CNT_W       = $clog2(PROD_W);

	localparam logic [1:0] REG_TABLE_ROWS = 2'd0;
	localparam logic [1:0] REG_X_LIMIT    = 2'd1;
	localparam logic [1:0] REG_Y_LIMIT    = 2'd2;

	localparam logic FUNC_LOAD    = 1'b0;
	localparam logic FUNC_CORRECT = 1'b1;

	typedef struct packed {
		logic               func;
		logic [5:0]         row_index;
		logic [BP_W-1:0]    breakpoint;
		logic signed [31:0] x_correction;
		logic signed [31:0] y_correction;
		logic signed [31:0] x_position;
		logic signed [31:0] y_position;
	} in_t;

	typedef struct packed {
		logic signed [31:0] new_x;
		logic signed [31:0] new_y;
		logic               x_miss;
		logic               y_miss;
	} out_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LAST_RD, ST_LAST_CHK, ST_SCAN_RD, ST_SCAN_CHK, ST_SEL,
		ST_MUL, ST_DIV_INIT, ST_DIV, ST_ADJ, ST_FIN
	} st_t;

	typedef struct packed {
		logic          mem_we;
		logic          start;
		logic [AW-1:0] addr;
		logic          last_chk;
		logic          scan_chk;
		logic          first_row;
		logic          axis;
		logic          mul;
		logic          div_init;
		logic          div_step;
		logic          adj;
		logic          out_load;
	} cmd_t;

	typedef struct packed {
		logic interp_x;
		logic interp_y;
	} status_t;

endpackage

/* sv/cbic_ctrl.sv */
// controller sequencing table search, interpolation divide and result handoff
module cbic_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_func,
	output logic                     in_stall,
	output logic                     out_valid,
	input  logic                     out_stall,
	input  logic [cbic_pkg::AW-1:0]  last_row,
	input  cbic_pkg::status_t        status,
	output cbic_pkg::cmd_t           cmd
);
	import cbic_pkg::*;

	st_t              state_q, state_d;
	logic [AW-1:0]    row_q, row_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             axis_q, axis_d;
	logic             out_valid_q;
	logic             accept;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			cnt_q       <= '0;
			axis_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
			cnt_q   <= cnt_d;
			axis_q  <= axis_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d       = state_q;
		row_d         = row_q;
		cnt_d         = cnt_q;
		axis_d        = axis_q;
		cmd           = '0;
		cmd.axis      = axis_q;
		cmd.addr      = row_q;
		cmd.first_row = (row_q == '0);
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_func == FUNC_LOAD) begin
						cmd.mem_we = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d   = ST_LAST_RD;
					end
				end
			end
			ST_LAST_RD: begin
				cmd.addr = last_row;
				state_d  = ST_LAST_CHK;
			end
			ST_LAST_CHK: begin
				cmd.last_chk = 1'b1;
				row_d        = '0;
				state_d      = ST_SCAN_RD;
			end
			ST_SCAN_RD: begin
				state_d = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				cmd.scan_chk = 1'b1;
				if (row_q == last_row) begin
					state_d = ST_SEL;
				end else begin
					row_d   = row_q + 1'b1;
					state_d = ST_SCAN_RD;
				end
			end
			ST_SEL: begin
				if (status.interp_x) begin
					axis_d  = 1'b0;
					state_d = ST_MUL;
				end else if (status.interp_y) begin
					axis_d  = 1'b1;
					state_d = ST_MUL;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV_INIT;
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				cnt_d        = '0;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(PROD_W - 1))
					state_d = ST_ADJ;
			end
			ST_ADJ: begin
				cmd.adj = 1'b1;
				if (!axis_q && status.interp_y) begin
					axis_d  = 1'b1;
					state_d = ST_MUL;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_event_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_func == FUNC_CORRECT) |=> state_q == ST_LAST_RD)
		else $error("event transaction did not start search");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && out_stall))
		else $error("result overwrote a stalled transaction");
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q < CNT_W'(PROD_W))
		else $error("divide step count overrun");
	a_div_to_adj: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == CNT_W'(PROD_W - 1)) |=> state_q == ST_ADJ)
		else $error("divide did not finish");
`endif

endmodule

/* sv/cbic_dp.sv */
// datapath: correction table, segment search compare, multiply, divide, output register
module cbic_dp (
	input  logic               clk,
	input  cbic_pkg::in_t      in_data,
	input  cbic_pkg::cmd_t     cmd,
	input  logic [14:0]        x_limit,
	input  logic [14:0]        y_limit,
	output cbic_pkg::status_t  status,
	output cbic_pkg::out_t     out_data
);
	import cbic_pkg::*;

	logic [BP_W-1:0]    mem_bp [TABLE_DEPTH];
	logic signed [31:0] mem_cx [TABLE_DEPTH];
	logic signed [31:0] mem_cy [TABLE_DEPTH];
	logic [BP_W-1:0]    rd_bp_q;
	logic signed [31:0] rd_cx_q, rd_cy_q;
	logic [BP_W-1:0]    prev_bp_q;
	logic signed [31:0] prev_cx_q, prev_cy_q;

	logic signed [31:0] posx_q, posy_q;
	logic [T2_W-1:0]    t2x_q, t2y_q;
	logic               hitx_q, hity_q, intx_q, inty_q;
	logic [BP_W-1:0]    b0x_q, b1x_q, b0y_q, b1y_q;
	logic signed [31:0] c0x_q, c1x_q, c0y_q, c1y_q;
	logic signed [31:0] valx_q, valy_q;

	logic signed [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0]        dvd_q;
	logic [T2_W-1:0]          rem_q, den_q;
	logic                     qneg_q;
	out_t                     out_q;

	logic [T2_W:0]      bp2_rd, bp2_prev;
	logic               segx, segy;
	logic [T2_W-1:0]    t2_a, b0_a, b1_a;
	logic signed [31:0] c0_a, c1_a;
	logic signed [T2_W:0] dt;
	logic signed [32:0] dc;
	logic signed [PROD_W-1:0] prod_full;
	logic [T2_W:0]      rem_sh;
	logic               qbit;
	logic signed [33:0] qs, sum_a;
	logic signed [31:0] resx, resy;

	function automatic logic [31:0] absv(input logic signed [31:0] v);
		absv = v[31] ? 32'(-v) : 32'(v);
	endfunction

	function automatic logic [T2_W-1:0] t2_of(input logic signed [31:0] v);
		logic [31:0] m;
		m = absv(v);
		t2_of = v[31] ? (T2_W'(32'd2097152) - T2_W'(m[15:0]))
		              : (T2_W'(32'd2097152) + T2_W'(m[15:0]));
	endfunction

	function automatic logic signed [31:0] fix(input logic signed [31:0] pos,
		input logic signed [31:0] val, input logic [14:0] lim);
		logic [31:0]        m;
		logic signed [33:0] v;
		m = absv(pos);
		v = pos[31] ? -34'(val) : 34'(val);
		if (v < $signed({3'b000, lim, 16'h0000}))
			v = v + $signed({2'b00, m[31:16], 16'h0000});
		if (v > 34'sd2147483647)
			fix = 32'sh7fffffff;
		else if (v < -34'sd2147483648)
			fix = 32'sh80000000;
		else
			fix = v[31:0];
	endfunction

	assign bp2_rd   = {1'b0, rd_bp_q, 1'b0};
	assign bp2_prev = {1'b0, prev_bp_q, 1'b0};
	assign segx     = ({1'b0, t2x_q} >= bp2_prev) && ({1'b0, t2x_q} < bp2_rd);
	assign segy     = ({1'b0, t2y_q} >= bp2_prev) && ({1'b0, t2y_q} < bp2_rd);

	assign t2_a = cmd.axis ? t2y_q : t2x_q;
	assign b0_a = cmd.axis ? {b0y_q, 1'b0} : {b0x_q, 1'b0};
	assign b1_a = cmd.axis ? {b1y_q, 1'b0} : {b1x_q, 1'b0};
	assign c0_a = cmd.axis ? c0y_q : c0x_q;
	assign c1_a = cmd.axis ? c1y_q : c1x_q;
	assign dt   = $signed({1'b0, t2_a}) - $signed({1'b0, b0_a});
	assign dc   = 33'(c1_a) - 33'(c0_a);
	assign prod_full = PROD_W'(dt) * PROD_W'(dc);

	assign rem_sh = {rem_q, dvd_q[PROD_W-1]};
	assign qbit   = (rem_sh >= {1'b0, den_q});
	assign qs     = qneg_q ? -34'(dvd_q[33:0]) : 34'(dvd_q[33:0]);
	assign sum_a  = 34'(c0_a) + qs;

	assign resx = fix(posx_q, valx_q, x_limit);
	assign resy = fix(posy_q, valy_q, y_limit);

	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			mem_bp[in_data.row_index] <= in_data.breakpoint;
			mem_cx[in_data.row_index] <= in_data.x_correction;
			mem_cy[in_data.row_index] <= in_data.y_correction;
		end
		rd_bp_q <= mem_bp[cmd.addr];
		rd_cx_q <= mem_cx[cmd.addr];
		rd_cy_q <= mem_cy[cmd.addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			posx_q <= in_data.x_position;
			posy_q <= in_data.y_position;
			t2x_q  <= t2_of(in_data.x_position);
			t2y_q  <= t2_of(in_data.y_position);
		end
		if (cmd.last_chk) begin
			hitx_q <= (t2x_q == {rd_bp_q, 1'b0});
			hity_q <= (t2y_q == {rd_bp_q, 1'b0});
			intx_q <= 1'b0;
			inty_q <= 1'b0;
			valx_q <= rd_cx_q;
			valy_q <= rd_cy_q;
		end
		if (cmd.scan_chk) begin
			prev_bp_q <= rd_bp_q;
			prev_cx_q <= rd_cx_q;
			prev_cy_q <= rd_cy_q;
			if (!cmd.first_row && !hitx_q && segx) begin
				hitx_q <= 1'b1;
				intx_q <= 1'b1;
				b0x_q  <= prev_bp_q;
				b1x_q  <= rd_bp_q;
				c0x_q  <= prev_cx_q;
				c1x_q  <= rd_cx_q;
			end
			if (!cmd.first_row && !hity_q && segy) begin
				hity_q <= 1'b1;
				inty_q <= 1'b1;
				b0y_q  <= prev_bp_q;
				b1y_q  <= rd_bp_q;
				c0y_q  <= prev_cy_q;
				c1y_q  <= rd_cy_q;
			end
		end
		if (cmd.mul)
			prod_q <= prod_full;
		if (cmd.div_init) begin
			qneg_q <= prod_q[PROD_W-1];
			dvd_q  <= prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
			rem_q  <= '0;
			den_q  <= b1_a - b0_a;
		end
		if (cmd.div_step) begin
			rem_q <= qbit ? T2_W'(rem_sh - {1'b0, den_q}) : rem_sh[T2_W-1:0];
			dvd_q <= {dvd_q[PROD_W-2:0], qbit};
		end
		if (cmd.adj) begin
			if (cmd.axis)
				valy_q <= sum_a[31:0];
			else
				valx_q <= sum_a[31:0];
		end
		if (cmd.out_load) begin
			out_q.new_x  <= hitx_q ? resx : posx_q;
			out_q.new_y  <= hity_q ? resy : posy_q;
			out_q.x_miss <= !hitx_q;
			out_q.y_miss <= !hity_q;
		end
	end

	assign status.interp_x = intx_q;
	assign status.interp_y = inty_q;
	assign out_data        = out_q;

endmodule

/* sv/centroid_bias_interp_correct_core.sv */
// top level of the centroid bias correction block: config registers and glue
// usage:
//  in channel (in_valid/in_stall/in_data): func 0 writes one table row and
//  gives no result; func 1 corrects one event and gives one result on the
//  out channel (out_valid/out_stall/out_data).
//  cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes table_rows,
//  x_limit, y_limit; write only while no event is in flight.
//  an event runs the table search (last row check, then one read and one
//  compare per row, then a select), then for each axis that interpolates a
//  multiply, a divide set-up, a 57-step bit-serial divide and an adjust,
//  and then the handoff to the output register; the next event is accepted
//  only after that handoff.
//  one event at a time; in_stall is high from acceptance until the result
//  enters the output register.
//  the output register holds a result while out_stall is high, and a new
//  event may be accepted meanwhile; its result waits until the old one leaves.
//  reset clears the control state and config registers (table_rows 2,
//  limits 512); table rows are undefined until loaded.
module centroid_bias_interp_correct_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  cbic_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output cbic_pkg::out_t  out_data,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_index,
	input  logic [14:0]     cfg_data
);
	import cbic_pkg::*;

	logic [6:0]    rows_q;
	logic [14:0]   xlim_q, ylim_q;
	logic [AW-1:0] last_row;
	cmd_t          cmd;
	status_t       status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 7'd2;
			xlim_q <= 15'd512;
			ylim_q <= 15'd512;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TABLE_ROWS: rows_q <= cfg_data[6:0];
				REG_X_LIMIT:    xlim_q <= cfg_data;
				REG_Y_LIMIT:    ylim_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	always_comb begin
		if (rows_q < 7'd2)
			last_row = AW'(1);
		else if (32'(rows_q) > TABLE_DEPTH)
			last_row = AW'(TABLE_DEPTH - 1);
		else
			last_row = AW'(rows_q - 7'd1);
	end

	cbic_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_func   (in_data.func),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.last_row  (last_row),
		.status    (status),
		.cmd       (cmd)
	);

	cbic_dp u_dp (
		.clk      (clk),
		.in_data  (in_data),
		.cmd      (cmd),
		.x_limit  (xlim_q),
		.y_limit  (ylim_q),
		.status   (status),
		.out_data (out_data)
	);

endmodule
